/* rtl/aemt_pkg.sv */
package aemt_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_LOWER_LIMIT = 2'd0,
		REG_UPPER_LIMIT = 2'd1,
		REG_REVERSE     = 2'd2
	} reg_index_t;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned DISP_W      = 32;

	// Handshake between the sequencer and the divider
	typedef struct packed {
		logic start;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* rtl/analog_encoder_multiturn_tracker.sv */
// Multi-turn tracker for an analog absolute encoder. Each sample beat is
// clamped to [lower_limit, upper_limit], scaled to a single-turn angle
// (2^ANGLE_BITS per turn, truncated) and its shortest wrapped step from the
// previous angle is added to a saturating 32-bit accumulator
// (+/-(2^31-1)). One result beat per sample: displacement (negated when
// reverse is set) and the angle. The first sample after reset only sets the
// reference. If upper_limit <= lower_limit the angle is 0. out_valid rises
// after a sample is accepted and the restoring divider has reduced the
// integer part and then retired one quotient bit per cycle; in_ready is
// low from acceptance until the result beat is taken, so no new sample is
// taken while one is in flight.
// Write configuration only while no sample is in flight.
module analog_encoder_multiturn_tracker #(
	parameter int unsigned ADC_BITS   = 12,
	parameter int unsigned ANGLE_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wen,
	input  logic [aemt_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [ADC_BITS-1:0]                    cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [ADC_BITS-1:0]                    sample,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [aemt_pkg::DISP_W-1:0]     displacement,
	output logic [ANGLE_BITS-1:0]                  angle
);

	localparam int unsigned DW  = aemt_pkg::DISP_W;
	localparam int unsigned DLW = ANGLE_BITS + 2;
	localparam logic signed [DLW-1:0] HALF = DLW'(1) << (ANGLE_BITS - 1);
	localparam logic signed [DLW-1:0] TURN = DLW'(1) << ANGLE_BITS;
	localparam logic signed [DW:0] ACC_MAX = {2'b00, {(DW-1){1'b1}}};
	localparam logic signed [DW:0] ACC_MIN = -ACC_MAX;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_DIV,
		S_ACC,
		S_OUT
	} state_t;

	state_t state_q;

	logic [ADC_BITS-1:0]   lower_q;
	logic [ADC_BITS-1:0]   upper_q;
	logic                  reverse_q;
	logic [ADC_BITS-1:0]   sample_q;
	logic [ANGLE_BITS-1:0] angle_q;
	logic [ANGLE_BITS-1:0] prev_q;
	logic signed [DW-1:0]  acc_q;
	logic                  have_ref_q;
	logic signed [DW-1:0]  disp_q;

	aemt_pkg::div_req_t    div_req;
	aemt_pkg::div_stat_t   div_stat;
	logic [ADC_BITS-1:0]   clamped;
	logic [ADC_BITS-1:0]   diff;
	logic [ADC_BITS-1:0]   span;
	logic                  limits_bad;
	logic [ANGLE_BITS-1:0] quot;
	logic signed [DLW-1:0] dlt;
	logic signed [DLW-1:0] dlt_wrap;
	logic signed [DW:0]    sum;
	logic signed [DW-1:0]  acc_sat;
	logic signed [DW-1:0]  acc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q   <= '0;
			upper_q   <= '1;
			reverse_q <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				aemt_pkg::REG_LOWER_LIMIT: lower_q   <= cfg_data;
				aemt_pkg::REG_UPPER_LIMIT: upper_q   <= cfg_data;
				aemt_pkg::REG_REVERSE:     reverse_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		limits_bad = upper_q <= lower_q;
		if (sample_q > upper_q) begin
			clamped = upper_q;
		end else if (sample_q < lower_q) begin
			clamped = lower_q;
		end else begin
			clamped = sample_q;
		end
		diff = clamped - lower_q;
		span = upper_q - lower_q;
	end

	assign div_req.start = state_q == S_PREP;

	aemt_div #(
		.ADC_BITS  (ADC_BITS),
		.ANGLE_BITS(ANGLE_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.diff  (diff),
		.span  (span),
		.stat  (div_stat),
		.quot  (quot)
	);

	// Shortest wrapped step, then saturating accumulate
	always_comb begin
		dlt = $signed({2'b00, angle_q}) - $signed({2'b00, prev_q});
		if (dlt > HALF) begin
			dlt_wrap = dlt - TURN;
		end else if (dlt < -HALF) begin
			dlt_wrap = dlt + TURN;
		end else begin
			dlt_wrap = dlt;
		end
		sum = $signed({acc_q[DW-1], acc_q})
			+ $signed({{(DW+1-DLW){dlt_wrap[DLW-1]}}, dlt_wrap});
		if (sum > ACC_MAX) begin
			acc_sat = ACC_MAX[DW-1:0];
		end else if (sum < ACC_MIN) begin
			acc_sat = ACC_MIN[DW-1:0];
		end else begin
			acc_sat = sum[DW-1:0];
		end
		acc_next = have_ref_q ? acc_sat : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			prev_q     <= '0;
			acc_q      <= '0;
			have_ref_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						sample_q <= sample;
						state_q  <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						angle_q <= limits_bad ? '0 : quot;
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					acc_q      <= acc_next;
					have_ref_q <= 1'b1;
					prev_q     <= angle_q;
					disp_q     <= reverse_q ? -acc_next : acc_next;
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready     = state_q == S_IDLE;
	assign out_valid    = state_q == S_OUT;
	assign displacement = disp_q;
	assign angle        = angle_q;

`ifndef SYNTHESIS
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == S_DIV)
		else $error("divider finished outside the divide phase");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready && !div_stat.busy)
		else $error("result beat overlaps sample intake or division");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> div_req.start)
		else $error("accepted sample did not start a division");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> displacement != {1'b1, {(DW-1){1'b0}}})
		else $error("displacement left the saturated range");
`endif

endmodule

/* rtl/aemt_div.sv */
module aemt_div #(
	parameter int unsigned ADC_BITS   = 12,
	parameter int unsigned ANGLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  aemt_pkg::div_req_t     req,
	input  logic [ADC_BITS-1:0]    diff,
	input  logic [ADC_BITS-1:0]    span,
	output aemt_pkg::div_stat_t    stat,
	output logic [ANGLE_BITS-1:0]  quot
);

	localparam int unsigned CNT_W = $clog2(ANGLE_BITS + 1);

	logic                  busy_q;
	logic                  done_q;
	logic                  pre_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [ADC_BITS:0]     rem_q;
	logic [ADC_BITS-1:0]   span_q;
	logic [ANGLE_BITS-1:0] quot_q;

	logic [ADC_BITS:0] trial;
	logic [ADC_BITS:0] diffr;
	logic              ge;

	// Shared compare/subtract unit: the first step reduces the integer part,
	// each later step shifts the remainder and yields one fraction bit.
	always_comb begin
		trial = pre_q ? rem_q : {rem_q[ADC_BITS-1:0], 1'b0};
		ge    = trial >= {1'b0, span_q};
		diffr = trial - {1'b0, span_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pre_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				pre_q  <= 1'b1;
				cnt_q  <= CNT_W'(ANGLE_BITS);
			end else if (busy_q) begin
				pre_q <= 1'b0;
				if (!pre_q) begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= {1'b0, diff};
			span_q <= span;
		end else if (busy_q) begin
			rem_q <= ge ? diffr : trial;
			if (!pre_q) begin
				quot_q <= {quot_q[ANGLE_BITS-2:0], ge};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;

endmodule

/* verif/analog_encoder_multiturn_tracker_tb.sv */
`timescale 1ns / 1ps

module analog_encoder_multiturn_tracker_tb;

	localparam int unsigned ADC_W   = 12;
	localparam int unsigned ANGLE_W = 16;
	localparam longint TURN         = 64'sd65536;
	localparam longint HALF_TURN    = 64'sd32768;
	localparam longint ACC_LIMIT    = 64'sd2147483647;
	localparam logic signed [aemt_pkg::DISP_W-1:0] DISP_MAX = 32'sh7FFF_FFFF;
	localparam logic [aemt_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam int unsigned SPIN_STEP    = 2047;
	localparam int unsigned SPIN_SAMPLES = 20;
	localparam int unsigned DRAIN_CYCLES = ANGLE_W + 24;
	localparam int unsigned LIMIT_CYCLES = 200_000;

	typedef struct packed {
		logic signed [aemt_pkg::DISP_W-1:0] displacement;
		logic [ANGLE_W-1:0]                 angle;
	} position_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [aemt_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [ADC_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [ADC_W-1:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [aemt_pkg::DISP_W-1:0] displacement;
	logic [ANGLE_W-1:0] angle;

	// predictor state and register shadow
	int lower_lim = 0;
	int upper_lim = 4095;
	bit reverse_dir = 1'b0;
	longint prev_angle = 0;
	longint turn_acc = 0;
	bit have_ref = 1'b0;

	logic [ADC_W-1:0] pending_samples[$];
	position_t expected_positions[$];
	int unsigned samples_sent = 0;
	int unsigned samples_taken = 0;
	int unsigned positions_checked = 0;
	int unsigned saturated_seen = 0;
	int unsigned mismatch_count = 0;
	int unsigned in_idle_pct = 0;
	int unsigned out_stall_pct = 0;
	int unsigned cycle_count = 0;

	analog_encoder_multiturn_tracker #(
		.ADC_BITS(ADC_W),
		.ANGLE_BITS(ANGLE_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.displacement(displacement),
		.angle(angle)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic position_t track_position(input logic [ADC_W-1:0] raw);
		position_t res;
		longint clamped, span, cur, step, sum, disp;
		cur = 0;
		if (upper_lim > lower_lim) begin
			clamped = raw;
			if (clamped > upper_lim)
				clamped = upper_lim;
			else if (clamped < lower_lim)
				clamped = lower_lim;
			span = upper_lim - lower_lim;
			cur = ((clamped - lower_lim) * TURN) / span;
			cur = cur % TURN;
		end
		if (have_ref) begin
			step = cur - prev_angle;
			// take the shortest way round; exactly half a turn keeps its sign
			if (step > HALF_TURN)
				step = step - TURN;
			else if (step < -HALF_TURN)
				step = step + TURN;
			sum = turn_acc + step;
			if (sum > ACC_LIMIT)
				sum = ACC_LIMIT;
			else if (sum < -ACC_LIMIT)
				sum = -ACC_LIMIT;
			turn_acc = sum;
		end else begin
			have_ref = 1'b1;
		end
		prev_angle = cur;
		disp = reverse_dir ? -turn_acc : turn_acc;
		res.displacement = disp[aemt_pkg::DISP_W-1:0];
		res.angle = cur[ANGLE_W-1:0];
		return res;
	endfunction

	always @(negedge clk) begin
		logic next_valid;
		logic [ADC_W-1:0] next_sample;
		next_valid = in_valid;
		next_sample = sample;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else if (!in_valid || samples_taken == samples_sent) begin
			next_valid = 1'b0;
			if (pending_samples.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
				next_valid = 1'b1;
				next_sample = pending_samples.pop_front();
				samples_sent++;
			end
		end
		in_valid <= next_valid;
		sample <= next_sample;
		out_ready <= arst_n && ($urandom_range(99) >= out_stall_pct);
	end

	always @(posedge clk) begin
		position_t got;
		position_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_positions.push_back(track_position(sample));
				samples_taken++;
			end
			if (out_valid && out_ready) begin
				got.displacement = displacement;
				got.angle = angle;
				if (expected_positions.size() == 0) begin
					$error("result beat with nothing pending: displacement %0d angle %0d",
						got.displacement, got.angle);
					mismatch_count++;
				end else begin
					want = expected_positions.pop_front();
					positions_checked++;
					if (want.displacement == DISP_MAX || want.displacement == -DISP_MAX)
						saturated_seen++;
					if (got.displacement !== want.displacement) begin
						$error("displacement: expected %0d, got %0d",
							want.displacement, got.displacement);
						mismatch_count++;
					end
					if (got.angle !== want.angle) begin
						$error("angle: expected %0d, got %0d", want.angle, got.angle);
						mismatch_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d positions still pending",
				cycle_count, expected_positions.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_samples.size() != 0 || in_valid || expected_positions.size() != 0
			|| !in_ready);
	endtask

	task automatic write_reg(input logic [aemt_pkg::CFG_INDEX_W-1:0] idx,
		input logic [ADC_W-1:0] value);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			aemt_pkg::REG_LOWER_LIMIT: lower_lim = value;
			aemt_pkg::REG_UPPER_LIMIT: upper_lim = value;
			aemt_pkg::REG_REVERSE:     reverse_dir = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic set_config(input int lo, input int hi, input bit rev);
		wait_drained();
		write_reg(aemt_pkg::REG_LOWER_LIMIT, lo[ADC_W-1:0]);
		write_reg(aemt_pkg::REG_UPPER_LIMIT, hi[ADC_W-1:0]);
		write_reg(aemt_pkg::REG_REVERSE, {{(ADC_W-1){1'b0}}, rev});
	endtask

	// mostly smooth rotation at random speed inside the limits, some noise
	task automatic queue_motion(input int unsigned count);
		int lo, hi, width, vmax, vel, jitter, pos;
		int unsigned left, run;
		logic [ADC_W-1:0] raw;
		lo = lower_lim;
		hi = upper_lim;
		if (hi <= lo) begin
			lo = 0;
			hi = 4095;
		end
		width = hi - lo + 1;
		vmax = (width / 3 > 1) ? width / 3 : 1;
		pos = $urandom_range(width - 1);
		pos = pos + lo;
		left = count;
		while (left > 0) begin
			if ($urandom_range(99) < 25) begin
				raw = $urandom_range(4095);
				pending_samples.push_back(raw);
				left--;
			end else begin
				run = $urandom_range(24, 4);
				vel = $urandom_range(2 * vmax);
				vel = vel - vmax;
				while (run > 0 && left > 0) begin
					jitter = $urandom_range(2);
					pos = lo + (((pos - lo + vel + jitter - 1) % width) + width) % width;
					raw = pos[ADC_W-1:0];
					pending_samples.push_back(raw);
					run--;
					left--;
				end
			end
		end
	endtask

	initial begin
		int lo, hi;
		int spin_pos;
		logic [ADC_W-1:0] raw;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// reset limits: first sample is the reference, a full turn wraps to zero
		wait_drained();
		pending_samples = '{12'd0, 12'd4095, 12'd1, 12'd4094, 12'd2048, 12'd4095, 12'd2047};

		// clamping below and above the limits, reported reversed
		set_config(100, 3000, 1'b1);
		pending_samples = '{12'd0, 12'd3500, 12'd100, 12'd1550, 12'd3000, 12'd2999, 12'd101};

		// two-count span: every step after the first is exactly half a turn
		set_config(0, 2, 1'b1);
		pending_samples = '{12'd1, 12'd2, 12'd1, 12'd0};

		// equal, then crossed limits hold the angle at zero
		set_config(2000, 2000, 1'b0);
		pending_samples = '{12'd4095, 12'd0};
		set_config(3000, 1000, 1'b0);
		pending_samples = '{12'd2000, 12'd4095};

		// unused index is dropped, reverse takes only bit 0
		wait_drained();
		write_reg(aemt_pkg::REG_REVERSE, 12'h001);
		write_reg(REG_UNUSED, 12'hFFF);
		write_reg(aemt_pkg::REG_REVERSE, 12'hFFE);
		write_reg(aemt_pkg::REG_LOWER_LIMIT, 12'd4094);
		write_reg(aemt_pkg::REG_UPPER_LIMIT, 12'd4095);
		pending_samples = '{12'd4095, 12'd4094, 12'd0};

		// random motion under four idle/stall mixes
		set_config(0, 4095, 1'b0);
		in_idle_pct = 0;
		out_stall_pct = 0;
		queue_motion(150);

		lo = $urandom_range(1500);
		hi = $urandom_range(4095, 2500);
		set_config(lo, hi, 1'b1);
		in_idle_pct = 52;
		out_stall_pct = 0;
		queue_motion(75);
		// hold off until everything in flight has come back
		wait_drained();
		queue_motion(75);

		lo = $urandom_range(4095);
		hi = $urandom_range(4095, lo);
		set_config(lo, hi, $urandom_range(1));
		in_idle_pct = 0;
		out_stall_pct = 52;
		queue_motion(150);

		set_config(1000, 1003, 1'b0);
		in_idle_pct = 7;
		out_stall_pct = 7;
		queue_motion(75);
		lo = $urandom_range(4095);
		hi = $urandom_range(4095);
		set_config(lo, hi, $urandom_range(1));
		queue_motion(75);

		// spin forward just under half a turn per sample
		set_config(0, 4095, 1'b0);
		in_idle_pct = 0;
		out_stall_pct = 0;
		spin_pos = 0;
		for (int unsigned k = 0; k < SPIN_SAMPLES; k++) begin
			raw = spin_pos[ADC_W-1:0];
			pending_samples.push_back(raw);
			spin_pos = (spin_pos + SPIN_STEP) % 4095;
		end
		// report reversed, then spin back the same way
		wait_drained();
		write_reg(aemt_pkg::REG_REVERSE, 12'h001);
		for (int unsigned k = 0; k < SPIN_SAMPLES; k++) begin
			spin_pos = (spin_pos + 4095 - SPIN_STEP) % 4095;
			raw = spin_pos[ADC_W-1:0];
			pending_samples.push_back(raw);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d samples, %0d positions checked, %0d of them saturated",
			samples_taken, positions_checked, saturated_seen);
		$display("limits at reset, clamped, two-count, equal, crossed, random and near-half spins;"
			, " four idle mixes");
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
